[design/tcht_pkg.sv]
// Shared types and constants for the touch calibrate and hit-test unit.
package tcht_pkg;

  localparam int SIZE_W     = 13;
  localparam int OUT_W      = 12;
  localparam int CNT_W      = 2;
  localparam int HIT_W      = 2;
  localparam int RECT_W     = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int REQ_W      = 3;

  // two-point calibration: offset and span of the raw reading
  localparam int CAL_X_LO  = 270;
  localparam int CAL_X_DIV = 3832 - 270;
  localparam int CAL_Y_LO  = 362;
  localparam int CAL_Y_DIV = 3617 - 362;
  localparam int OUT_MAX   = 4095;

  localparam int RECT_REGS = 2;
  localparam logic [RECT_W-1:0] RECT_RESET [RECT_REGS] = '{
    64'd8445022401986630,
    64'd95702265182289990
  };

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd480;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd272;
  localparam logic [CNT_W-1:0]  COUNT_RESET  = 2'd2;

  typedef enum logic [REQ_W-1:0] {
    REQ_AXIS_X  = 3'd0,
    REQ_AXIS_Y  = 3'd1,
    REQ_PRESS   = 3'd2,
    REQ_RELEASE = 3'd3,
    REQ_OTHER   = 3'd4
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH     = 3'd0,
    REG_SCREEN_HEIGHT    = 3'd1,
    REG_ACTIVE_BUTTONS   = 3'd2,
    REG_BUTTON_ZERO_RECT = 3'd3,
    REG_BUTTON_ONE_RECT  = 3'd4
  } cfg_reg_t;

endpackage

[design/tcht_if.sv]
// Channel interfaces: touch events in, calibrated points out, register writes.
interface tcht_in_if
  import tcht_pkg::*;
#(
  parameter int RAW_BITS = 12
);
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [RAW_BITS-1:0] axis_value;

  modport source (output valid, output req_type, output axis_value, input ready);
  modport sink   (input valid, input req_type, input axis_value, output ready);
endinterface

interface tcht_out_if
  import tcht_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] screen_x;
  logic [OUT_W-1:0] screen_y;
  logic [HIT_W-1:0] button_hit;

  modport source (output valid, output screen_x, output screen_y, output button_hit,
                  input ready);
  modport sink   (input valid, input screen_x, input screen_y, input button_hit,
                  output ready);
endinterface

interface tcht_cfg_if
  import tcht_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

[design/touch_calibrate_and_hit_test_unit.sv]
// Touch calibrate and hit-test unit: raw X/Y events to screen point and button.
//
//   channel  dir  payload                             transaction when
//   in_ch    in   req_type, axis_value                valid && ready
//   out_ch   out  screen_x, screen_y, button_hit      valid && ready
//   cfg_ch   in   idx, data                           valid && ready (ready always 1)
//
// One event per cycle while in_ch.ready is high. A Y event passes, after acceptance,
// the registered stages scale multiply, reciprocal divide, then clamp and rectangle test.
// X, press, release and other events are consumed in the cycle they are accepted.
// Each stage advances whenever the stage after it is free or moving, so a
// stalled output holds only as far back as the pipeline is full.
// Synchronous reset restores the register defaults and clears latched X.
module touch_calibrate_and_hit_test_unit
  import tcht_pkg::*;
#(
  parameter int MAX_BUTTONS = 2,
  parameter int RAW_BITS    = 12
) (
  input  logic clk,
  input  logic rst_n,
  tcht_in_if.sink    in_ch,
  tcht_out_if.source out_ch,
  tcht_cfg_if.sink   cfg_ch
);

  localparam int NUM_RECTS = (MAX_BUTTONS < RECT_REGS) ? MAX_BUTTONS : RECT_REGS;
  localparam int DW   = RAW_BITS + 2;       // signed offset reading
  localparam int MAGW = RAW_BITS + 1;       // its magnitude
  localparam int NW   = MAGW + SIZE_W;      // magnitude times screen size
  localparam int QW   = NW - 11;            // quotient; both spans exceed 2^11
  localparam int PW   = NW + QW;
  localparam int CW   = ((QW > SIZE_W) ? QW : SIZE_W) + 2;
  localparam logic [QW-1:0] RECIP_X = QW'((64'd1 << NW) / CAL_X_DIV);
  localparam logic [QW-1:0] RECIP_Y = QW'((64'd1 << NW) / CAL_Y_DIV);

  // configuration
  logic [SIZE_W-1:0] scr_w_r, scr_h_r;
  logic [CNT_W-1:0]  act_btn_r;
  logic [RECT_W-1:0] rect_r [NUM_RECTS];

  logic [RAW_BITS-1:0] latched_x_r;

  // pipeline
  logic          s1_vld_r, s2_vld_r, out_vld_r;
  logic          s1_en, s2_en, out_en;
  logic          in_acc, acc_y;
  logic [NW-1:0] s1_nx_r, s1_ny_r, nx_nxt, ny_nxt;
  logic          s1_sx_r, s1_sy_r;
  logic [QW-1:0] s2_qx_r, s2_qy_r, qx_nxt, qy_nxt;
  logic          s2_sx_r, s2_sy_r;
  logic [OUT_W-1:0] out_x_r, out_y_r, cx_nxt, cy_nxt;
  logic [HIT_W-1:0] out_hit_r, hit_nxt;

  assign out_en = !out_vld_r || out_ch.ready;
  assign s2_en  = !s2_vld_r || out_en;
  assign s1_en  = !s1_vld_r || s2_en;

  assign in_ch.ready = s1_en;
  assign in_acc      = in_ch.valid && s1_en;
  assign acc_y       = in_acc && (in_ch.req_type == REQ_AXIS_Y);

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r   <= WIDTH_RESET;
      scr_h_r   <= HEIGHT_RESET;
      act_btn_r <= COUNT_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.idx)
        REG_SCREEN_WIDTH:   scr_w_r   <= cfg_ch.data[SIZE_W-1:0];
        REG_SCREEN_HEIGHT:  scr_h_r   <= cfg_ch.data[SIZE_W-1:0];
        REG_ACTIVE_BUTTONS: act_btn_r <= cfg_ch.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_RECTS; i++) begin
        rect_r[i] <= RECT_RESET[i];
      end
    end else if (cfg_ch.valid) begin
      for (int i = 0; i < NUM_RECTS; i++) begin
        if (cfg_ch.idx == CFG_IDX_W'(int'(REG_BUTTON_ZERO_RECT) + i)) begin
          rect_r[i] <= cfg_ch.data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_x_r <= '0;
    end else if (in_acc) begin
      if (in_ch.req_type == REQ_AXIS_X) begin
        latched_x_r <= in_ch.axis_value;
      end else if (in_ch.req_type == REQ_AXIS_Y) begin
        latched_x_r <= '0;
      end
    end
  end

  // stage 1: offset, magnitude, scale by screen size
  always_comb begin
    logic signed [DW-1:0] dx, dy;
    logic [MAGW-1:0]      mx, my;
    dx = signed'({2'b00, latched_x_r}) - DW'(CAL_X_LO);
    dy = signed'({2'b00, in_ch.axis_value}) - DW'(CAL_Y_LO);
    mx = dx[DW-1] ? MAGW'(-dx) : MAGW'(dx);
    my = dy[DW-1] ? MAGW'(-dy) : MAGW'(dy);
    nx_nxt = NW'(mx) * NW'(scr_w_r);
    ny_nxt = NW'(my) * NW'(scr_h_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_en) begin
      s1_vld_r <= acc_y;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_nx_r <= nx_nxt;
      s1_ny_r <= ny_nxt;
      s1_sx_r <= (latched_x_r < RAW_BITS'(CAL_X_LO)) || (RAW_BITS < 9);
      s1_sy_r <= (in_ch.axis_value < RAW_BITS'(CAL_Y_LO)) || (RAW_BITS < 9);
    end
  end

  // stage 2: magnitude / span by reciprocal; estimate is low by at most one
  always_comb begin
    logic [PW-1:0] px, py;
    logic [QW-1:0] q0x, q0y;
    logic [NW-1:0] rx, ry;
    px  = PW'(s1_nx_r) * PW'(RECIP_X);
    py  = PW'(s1_ny_r) * PW'(RECIP_Y);
    q0x = px[PW-1:NW];
    q0y = py[PW-1:NW];
    rx  = s1_nx_r - NW'(NW'(q0x) * NW'(CAL_X_DIV));
    ry  = s1_ny_r - NW'(NW'(q0y) * NW'(CAL_Y_DIV));
    qx_nxt = (rx >= NW'(CAL_X_DIV)) ? q0x + 1'b1 : q0x;
    qy_nxt = (ry >= NW'(CAL_Y_DIV)) ? q0y + 1'b1 : q0y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_qx_r <= qx_nxt;
      s2_qy_r <= qy_nxt;
      s2_sx_r <= s1_sx_r;
      s2_sy_r <= s1_sy_r;
    end
  end

  // stage 3: sign, clamp, first matching rectangle
  function automatic logic [OUT_W-1:0] clamp_coord(input logic signed [CW-1:0] v,
                                                   input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] top;
    top = size - 1'b1;
    if (top > SIZE_W'(OUT_MAX)) top = SIZE_W'(OUT_MAX);
    if (size == '0 || v < 0) return '0;
    if (v > signed'(CW'(top))) return top[OUT_W-1:0];
    return v[OUT_W-1:0];
  endfunction

  always_comb begin
    logic signed [CW-1:0] vx, vy;
    logic [15:0] left, top, wd, ht;
    vx = CW'(s2_qx_r);
    if (s2_sx_r) vx = -vx;
    vy = s2_sy_r ? CW'(scr_h_r) + CW'(s2_qy_r) : CW'(scr_h_r) - CW'(s2_qy_r);
    cx_nxt = clamp_coord(vx, scr_w_r);
    cy_nxt = clamp_coord(vy, scr_h_r);
    hit_nxt = '0;
    // walk backwards so the lowest matching index is kept
    for (int i = NUM_RECTS - 1; i >= 0; i--) begin
      left = rect_r[i][63:48];
      top  = rect_r[i][47:32];
      wd   = rect_r[i][31:16];
      ht   = rect_r[i][15:0];
      if ((CNT_W'(i) < act_btn_r) &&
          (left < 16'(cx_nxt)) && ({1'b0, left} + {1'b0, wd} > 17'(cx_nxt)) &&
          (top < 16'(cy_nxt)) && ({1'b0, top} + {1'b0, ht} > 17'(cy_nxt))) begin
        hit_nxt = HIT_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_en) begin
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s2_vld_r) begin
      out_x_r   <= cx_nxt;
      out_y_r   <= cy_nxt;
      out_hit_r <= hit_nxt;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.screen_x   = out_x_r;
  assign out_ch.screen_y   = out_y_r;
  assign out_ch.button_hit = out_hit_r;

  // only Y events reach the datapath
  a_only_y_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.req_type != REQ_AXIS_Y) |=> !s1_vld_r)
    else $error("non-Y event entered the datapath");

  a_y_clears_x: assert property (@(posedge clk) disable iff (!rst_n)
    acc_y |=> (latched_x_r == '0))
    else $error("latched X not cleared by Y event");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_vld_r && out_vld_r && !out_ch.ready) |=> s2_vld_r)
    else $error("stage 2 transaction lost under output stall");

  a_x_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ((scr_w_r == '0 && out_x_r == '0) || (SIZE_W'(out_x_r) < scr_w_r)))
    else $error("screen_x outside the screen");

endmodule

[verif/tb.sv]
// Self-checking testbench for the touch calibrate and hit-test unit.
module tb
  import tcht_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BUTTONS  = 2;
  localparam int RAW_BITS     = 12;
  localparam int RAW_MAX      = (1 << RAW_BITS) - 1;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 100;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 5000;
  localparam logic [REQ_W-1:0]     REQ_CODE_MAX = '1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX  = '1;

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [HIT_W-1:0] hit;
  } touch_point_t;

  // Tracks register state and latched X, predicts each calibrated point.
  class touch_point_board;
    logic [SIZE_W-1:0]   scr_w;
    logic [SIZE_W-1:0]   scr_h;
    logic [CNT_W-1:0]    btn_count;
    logic [RECT_W-1:0]   rect [RECT_REGS];
    logic [RAW_BITS-1:0] latched_x;
    touch_point_t        expected_points [$];
    int                  errors;
    int                  points;
    int                  hits [4];

    function new();
      scr_w     = WIDTH_RESET;
      scr_h     = HEIGHT_RESET;
      btn_count = COUNT_RESET;
      rect[0]   = RECT_RESET[0];
      rect[1]   = RECT_RESET[1];
      latched_x = '0;
      errors    = 0;
      points    = 0;
      hits      = '{default: 0};
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SCREEN_WIDTH:     scr_w = data[SIZE_W-1:0];
        REG_SCREEN_HEIGHT:    scr_h = data[SIZE_W-1:0];
        REG_ACTIVE_BUTTONS:   btn_count = data[CNT_W-1:0];
        REG_BUTTON_ZERO_RECT: rect[0] = data;
        REG_BUTTON_ONE_RECT:  rect[1] = data;
        default: ;
      endcase
    endfunction

    function longint clamp_axis(longint v, logic [SIZE_W-1:0] size);
      longint top;
      if (size == 0) return 0;
      top = longint'(size) - 1;
      if (top > OUT_MAX) top = OUT_MAX;
      if (v < 0) v = 0;
      if (v > top) v = top;
      return v;
    endfunction

    // strict bounds, edges formed at full width so they never wrap
    function logic [HIT_W-1:0] find_button(longint cx, longint cy);
      int     n;
      int     i;
      longint l, t, w, h;
      n = int'(btn_count);
      if (n > MAX_BUTTONS) n = MAX_BUTTONS;
      if (n > RECT_REGS) n = RECT_REGS;
      for (i = 0; i < n; i++) begin
        l = longint'(rect[i][63:48]);
        t = longint'(rect[i][47:32]);
        w = longint'(rect[i][31:16]);
        h = longint'(rect[i][15:0]);
        if (l < cx && l + w > cx && t < cy && t + h > cy) return HIT_W'(i + 1);
      end
      return '0;
    endfunction

    function void note_event(logic [REQ_W-1:0] req, logic [RAW_BITS-1:0] val);
      touch_point_t p;
      longint       cx, cy;
      if (req == REQ_AXIS_X) begin
        latched_x = val;
      end else if (req == REQ_AXIS_Y) begin
        cx = ((longint'(latched_x) - CAL_X_LO) * longint'(scr_w)) / CAL_X_DIV;
        cy = longint'(scr_h) - ((longint'(val) - CAL_Y_LO) * longint'(scr_h)) / CAL_Y_DIV;
        cx = clamp_axis(cx, scr_w);
        cy = clamp_axis(cy, scr_h);
        p.x   = cx[OUT_W-1:0];
        p.y   = cy[OUT_W-1:0];
        p.hit = find_button(cx, cy);
        expected_points.push_back(p);
        latched_x = '0;
      end
    endfunction

    function void check_point(logic [OUT_W-1:0] sx, logic [OUT_W-1:0] sy,
                              logic [HIT_W-1:0] hit);
      touch_point_t p;
      if (expected_points.size() == 0) begin
        $error("unexpected point x=%0d y=%0d button_hit=%0d", sx, sy, hit);
        errors++;
        return;
      end
      p = expected_points.pop_front();
      points++;
      hits[p.hit]++;
      if (sx !== p.x) begin
        $error("screen_x mismatch: expected %0d, got %0d", p.x, sx);
        errors++;
      end
      if (sy !== p.y) begin
        $error("screen_y mismatch: expected %0d, got %0d", p.y, sy);
        errors++;
      end
      if (hit !== p.hit) begin
        $error("button_hit mismatch: expected %0d, got %0d", p.hit, hit);
        errors++;
      end
    endfunction

    function int pending();
      return expected_points.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tcht_in_if #(.RAW_BITS(RAW_BITS)) in_ch ();
  tcht_out_if                       out_ch ();
  tcht_cfg_if                       cfg_ch ();

  touch_calibrate_and_hit_test_unit #(
    .MAX_BUTTONS(MAX_BUTTONS),
    .RAW_BITS   (RAW_BITS)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  touch_point_board board;
  int send_idle_pct = 23;
  int recv_idle_pct = 82;
  int axis_items    = 0;
  int ignored_items = 0;
  int settings      = 0;
  int stall_cycles  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_point(out_ch.screen_x, out_ch.screen_y, out_ch.button_hit);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $error("no transaction for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_event(input logic [REQ_W-1:0] req, input logic [RAW_BITS-1:0] val);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.req_type   = req;
    in_ch.axis_value = val;
    do @(posedge clk); while (!in_ch.ready);
    board.note_event(req, val);
    if (req == REQ_AXIS_X || req == REQ_AXIS_Y) axis_items++;
    else ignored_items++;
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.idx   = idx;
    cfg_ch.data  = data;
    do @(posedge clk); while (!cfg_ch.ready);
    board.write_reg(idx, data);
  endtask

  // every register plus one write to an unmapped index, which must be dropped
  task automatic apply_setting(input int w, input int h, input int cnt,
                               input logic [RECT_W-1:0] r0, input logic [RECT_W-1:0] r1);
    write_cfg(REG_SCREEN_WIDTH, CFG_DATA_W'(w));
    write_cfg(REG_SCREEN_HEIGHT, CFG_DATA_W'(h));
    write_cfg(REG_ACTIVE_BUTTONS, CFG_DATA_W'(cnt));
    write_cfg(REG_BUTTON_ZERO_RECT, r0);
    write_cfg(REG_BUTTON_ONE_RECT, r1);
    write_cfg(CFG_IDX_W'($urandom_range(REG_BUTTON_ONE_RECT + 1, CFG_IDX_MAX)),
              {$urandom, $urandom});
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    settings++;
  endtask

  // hold the sender until every point is out and the pipeline has emptied
  task automatic wait_until_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [RECT_W-1:0] random_rect(input int sx, input int sy);
    int lx, ly;
    if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
    lx = (sx > 4096) ? 4096 : sx;
    ly = (sy > 4096) ? 4096 : sy;
    return {16'($urandom_range(0, lx)), 16'($urandom_range(0, ly)),
            16'($urandom_range(1, lx / 2 + 1)), 16'($urandom_range(1, ly / 2 + 1))};
  endfunction

  function automatic logic [RAW_BITS-1:0] random_axis();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return RAW_BITS'(RAW_MAX);
      default: return RAW_BITS'($urandom_range(0, RAW_MAX));
    endcase
  endfunction

  function automatic logic [REQ_W-1:0] random_noise();
    return REQ_W'($urandom_range(REQ_PRESS, REQ_CODE_MAX));
  endfunction

  task automatic run_phase(input int target);
    int n;
    int roll;
    n = 0;
    while (n < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        send_event(REQ_AXIS_X, random_axis());
        if ($urandom_range(0, 4) == 0) send_event(random_noise(), random_axis());
        send_event(REQ_AXIS_Y, random_axis());
        n += 2;
      end else if (roll < 85) begin
        send_event(REQ_AXIS_Y, random_axis());
        n++;
      end else if (roll < 92) begin
        send_event(REQ_AXIS_X, random_axis());
        n++;
      end else begin
        send_event(random_noise(), random_axis());
      end
    end
  endtask

  initial begin
    int phase;
    int w, h;
    board = new();
    in_ch.valid      = 1'b0;
    in_ch.req_type   = REQ_OTHER;
    in_ch.axis_value = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.idx       = REG_SCREEN_WIDTH;
    cfg_ch.data      = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: Y with nothing latched, calibration corners, both buttons,
    // ignored codes that must not disturb latched X, X overwrite, Y after Y
    send_event(REQ_AXIS_Y, 12'd2000);
    send_event(REQ_AXIS_X, 12'd0);
    send_event(REQ_AXIS_Y, 12'd0);
    send_event(REQ_AXIS_X, 12'd4095);
    send_event(REQ_AXIS_Y, 12'd4095);
    send_event(REQ_AXIS_X, 12'd864);
    send_event(REQ_AXIS_Y, 12'd1045);
    send_event(REQ_AXIS_X, 12'd3165);
    send_event(REQ_AXIS_Y, 12'd1045);
    send_event(REQ_AXIS_X, RAW_BITS'(CAL_X_LO));
    send_event(REQ_AXIS_Y, RAW_BITS'(CAL_Y_LO));
    send_event(REQ_AXIS_X, RAW_BITS'(CAL_X_LO + CAL_X_DIV));
    send_event(REQ_AXIS_Y, RAW_BITS'(CAL_Y_LO + CAL_Y_DIV));
    send_event(REQ_AXIS_X, 12'd1000);
    send_event(REQ_PRESS, 12'd4095);
    send_event(REQ_RELEASE, 12'd0);
    send_event(REQ_OTHER, 12'd4095);
    send_event(REQ_W'(REQ_OTHER + 1), 12'd2048);
    send_event(REQ_W'(REQ_OTHER + 2), 12'd1365);
    send_event(REQ_CODE_MAX, 12'd2730);
    send_event(REQ_AXIS_Y, 12'd1500);
    send_event(REQ_AXIS_X, 12'd100);
    send_event(REQ_AXIS_X, 12'd2000);
    send_event(REQ_AXIS_Y, 12'd500);
    send_event(REQ_AXIS_Y, 12'd3000);

    for (phase = 0; phase < PHASES; phase++) begin
      wait_until_idle();
      case (phase)
        0: apply_setting(4096, 4096, 2, random_rect(4096, 4096), random_rect(4096, 4096));
        1: apply_setting(1, 1, 3, random_rect(1, 1), random_rect(1, 1));
        2: apply_setting(0, 0, 1, random_rect(0, 0), random_rect(0, 0));
        3: apply_setting(8191, 8191, 0, random_rect(4096, 4096), random_rect(4096, 4096));
        // unwrapped edge sum on the first rect, near-full-screen second rect
        4: apply_setting(480, 272, 2, '1, {32'd0, 16'hFFFF, 16'hFFFF});
        default: begin
          w = $urandom_range(1, 4096);
          h = $urandom_range(1, 4096);
          apply_setting(w, h, $urandom_range(0, 3), random_rect(w, h), random_rect(w, h));
        end
      endcase
      if (phase < 3) begin
        send_idle_pct = 23;
        recv_idle_pct = 82;
      end else if (phase < 6) begin
        send_idle_pct = 82;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      run_phase(PHASE_ITEMS);
    end
    wait_until_idle();

    $display("Drove %0d axis events and %0d ignored events over %0d register settings.",
             axis_items, ignored_items, settings);
    $display("Checked %0d points: %0d off buttons, %0d on button 1, %0d on button 2.",
             board.points, board.hits[0], board.hits[1], board.hits[2]);
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/tcht_pkg.sv
design/tcht_if.sv
design/touch_calibrate_and_hit_test_unit.sv
verif/tb.sv
